// ===== sv/dual_stack_shared_memory_assert.svh =====
// Assertion macros shared by the checker of the dual stack block
`ifndef DUAL_STACK_SHARED_MEMORY_ASSERT_SVH
`define DUAL_STACK_SHARED_MEMORY_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define DSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define DSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dssm_pkg.sv =====
// Package: types, codes and constants of the dual stack block
package dssm_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 7;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 40;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    REQ_PUSH_LO = 3'd0,
    REQ_PUSH_HI = 3'd1,
    REQ_POP_LO  = 3'd2,
    REQ_POP_HI  = 3'd3,
    REQ_PEEK_LO = 3'd4,
    REQ_PEEK_HI = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic exec;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== sv/dssm_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== sv/dssm_ctrl.sv =====
// Controller: sequences accept, store access and result load
module dssm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  dssm_pkg::sts_t sts,
  output dssm_pkg::cmd_t cmd
);
  import dssm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.take     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dssm_dpath.sv =====
// Datapath: stack counts, capacity, shared store and result register
module dssm_dpath #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dssm_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dssm_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_we,
  input  logic [dssm_pkg::CAP_W-1:0] cfg_wdata,
  input  dssm_pkg::cmd_t             cmd,
  output dssm_pkg::sts_t             sts
);
  import dssm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  req_t              req_r;
  logic [DATA_W-1:0] val_r;
  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     low_r, low_nxt;
  logic [CW-1:0]     high_r, high_nxt;
  status_t           st_r, st_nxt;
  logic              use_rd_r, use_rd_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_st_r;

  logic [XW-1:0]     cap_x;
  logic [CW-1:0]     eff_cap;
  logic [CW:0]       fill;
  logic              full;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Effective capacity, saturated to the store depth
  assign cap_x   = XW'(cap_r);
  assign eff_cap = (cap_x > XW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_x);
  assign fill    = {1'b0, low_r} + {1'b0, high_r};
  assign full    = (fill >= {1'b0, eff_cap});

  // Decode the held request into store access and count updates
  always_comb begin
    low_nxt    = low_r;
    high_nxt   = high_r;
    st_nxt     = ST_OK;
    use_rd_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = AW'(low_r);
    ram_raddr  = AW'(low_r - CW'(1));
    unique case (req_r) inside
      REQ_PUSH_LO: begin
        if (full) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(low_r);
          low_nxt   = low_r + CW'(1);
        end
      end
      REQ_PUSH_HI: begin
        if (full) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(eff_cap - CW'(1) - high_r);
          high_nxt  = high_r + CW'(1);
        end
      end
      REQ_POP_LO, REQ_PEEK_LO: begin
        if (low_r == '0) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          ram_re     = 1'b1;
          use_rd_nxt = 1'b1;
          ram_raddr  = AW'(low_r - CW'(1));
          if (req_r == REQ_POP_LO) begin
            low_nxt = low_r - CW'(1);
          end
        end
      end
      REQ_POP_HI, REQ_PEEK_HI: begin
        if (high_r == '0) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          ram_re     = 1'b1;
          use_rd_nxt = 1'b1;
          ram_raddr  = AW'(eff_cap - high_r);
          if (req_r == REQ_POP_HI) begin
            high_nxt = high_r - CW'(1);
          end
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r <= req_t'(in_tdata[2:0]);
      val_r <= in_tdata[34:3];
    end
  end

  // Counts, capacity and execute outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      high_r   <= '0;
      cap_r    <= CAP_RESET;
      st_r     <= ST_OK;
      use_rd_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        low_r    <= low_nxt;
        high_r   <= high_nxt;
        st_r     <= st_nxt;
        use_rd_r <= use_rd_nxt;
      end
      // Take a new capacity only while both stacks are empty
      if (cfg_we && low_r == '0 && high_r == '0) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  dssm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (cmd.exec & ram_we),
    .waddr  (ram_waddr),
    .wdata  (val_r),
    .re     (cmd.exec & ram_re),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  // Result register: load on command, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= use_rd_r ? ram_rdata : '0;
      out_st_r   <= st_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {6'd0, out_st_r, out_data_r};

endmodule

// ===== sv/dual_stack_shared_memory.sv =====
// Top level: two stacks sharing one store, stream request and result ports
//
// Two stacks live in one store of DEPTH 32-bit words: the low stack grows up
// from entry 0, the high stack grows down from entry capacity-1 (capacity
// saturates at DEPTH). Each request pushes, pops or peeks one stack and gives
// one result with a value and a status (ok, overflow, underflow); a push when
// the stacks fill the capacity is dropped with overflow, a pop or peek of an
// empty stack gives underflow and value zero. A request passes through accept,
// one store access, then the result load, the registered read of the store
// RAM setting the middle step; the result load waits until the result
// register is free, a new request is taken only after the previous result is
// loaded, and a request may be accepted while the previous result still waits.
// Write capacity only while idle; it is ignored unless both stacks are empty.
module dual_stack_shared_memory #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [2:0] req_type, [34:3] push_value, [39:35] zero
  input  logic [dssm_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] read_value, [33:32] status, [39:34] zero
  output logic [dssm_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_we,
  input  logic [dssm_pkg::CAP_W-1:0] cfg_wdata
);
  import dssm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dssm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dssm_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sv/dssm_checker.sv =====
// Port checker for the dual stack block and its bind
`include "dual_stack_shared_memory_assert.svh"

module dssm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [dssm_pkg::OUT_W-1:0] out_tdata
);
  import dssm_pkg::*;

  logic [DATA_W-1:0] out_value;
  logic [1:0]        out_status;
  logic              status_known;
  logic              out_stall;
  logic              out_err;
  logic              in_take;

  // Split the result and name the handshake conditions
  assign out_value    = out_tdata[DATA_W-1:0];
  assign out_status   = out_tdata[DATA_W+1:DATA_W];
  assign status_known = (out_status == ST_OK) || (out_status == ST_OVERFLOW) ||
                        (out_status == ST_UNDERFLOW);
  assign out_stall    = out_tvalid && !out_tready;
  assign out_err      = out_tvalid && (out_status != ST_OK);
  assign in_take      = in_tvalid && in_tready;

  // Stalled result holds its value
  `DSSM_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "result moved")

  // Only ok, overflow and underflow appear as status
  `DSSM_ASSERT_NOW(a_status_code, out_tvalid, status_known, "invalid status code")

  // Overflow and underflow results carry a zero value
  `DSSM_ASSERT_NOW(a_err_zero, out_err, out_value == '0, "error with nonzero value")

  // One request in flight: ready drops after an accept
  `DSSM_ASSERT_NEXT(a_one_inflight, in_take, !in_tready, "second request taken while busy")

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== bench/dual_stack_shared_memory_tb.sv =====
// Testbench for the dual stack block: directed and random requests against a shadow model
module dual_stack_shared_memory_tb;
  import dssm_pkg::*;

  localparam int DEPTH = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [1:0]        status;
  } stack_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the two stacks
  logic [DATA_W-1:0] shadow_store [DEPTH];
  int unsigned       low_depth = 0;
  int unsigned       high_depth = 0;
  logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

  stack_result_t     pending_results [$];
  int                in_idle_pct = 0;
  int                out_idle_pct = 0;
  int                fail_count = 0;
  int                req_count = 0;
  int                result_count = 0;
  int                overflow_count = 0;
  int                underflow_count = 0;
  int                cap_write_count = 0;

  dual_stack_shared_memory #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow stacks and return the result it should give
  function automatic stack_result_t apply_request(input logic [2:0] kind,
                                                  input logic [DATA_W-1:0] word);
    stack_result_t r;
    int unsigned   cap;
    logic          full;
    cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    full = (low_depth + high_depth) >= cap;
    r.value = '0;
    r.status = ST_OK;
    case (kind)
      REQ_PUSH_LO: begin
        if (full) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_store[low_depth] = word;
          low_depth++;
        end
      end
      REQ_PUSH_HI: begin
        if (full) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_store[cap - 1 - high_depth] = word;
          high_depth++;
        end
      end
      REQ_POP_LO, REQ_PEEK_LO: begin
        if (low_depth == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.value = shadow_store[low_depth - 1];
          if (kind == REQ_POP_LO) low_depth--;
        end
      end
      REQ_POP_HI, REQ_PEEK_HI: begin
        if (high_depth == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.value = shadow_store[cap - high_depth];
          if (kind == REQ_POP_HI) high_depth--;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Track capacity writes and predict every request taken at the coming edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (cfg_we && low_depth == 0 && high_depth == 0) shadow_cap = cfg_wdata;
      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_request(in_tdata[2:0], in_tdata[DATA_W+2:3]));
        req_count++;
      end
    end
  end

  // Compare each result taken at the coming edge with the oldest prediction
  always @(negedge clk) begin : result_check
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %h status %0d",
               out_tdata[DATA_W-1:0], out_tdata[DATA_W+1:DATA_W]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.status == ST_OVERFLOW) overflow_count++;
        if (want.status == ST_UNDERFLOW) underflow_count++;
        if (out_tdata[DATA_W-1:0] !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, out_tdata[DATA_W-1:0]);
          fail_count++;
        end
        if (out_tdata[DATA_W+1:DATA_W] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 out_tdata[DATA_W+1:DATA_W]);
          fail_count++;
        end
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no handshake for %0d cycles, %0d results pending",
             QUIET_LIMIT, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic [2:0] kind, input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W-DATA_W-3){1'b0}}, word, kind};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic finish_batch();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    finish_batch();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_write_count++;
  endtask

  // Pop both stacks down to empty, peeking now and then, and end on underflow
  task automatic empty_stacks(output int sent);
    int n_lo;
    int n_hi;
    finish_batch();
    n_lo = low_depth;
    n_hi = high_depth;
    sent = n_lo + n_hi + 2;
    repeat (n_lo) begin
      if ($urandom_range(3) == 0) begin
        send_request(REQ_PEEK_LO, $urandom);
        sent++;
      end
      send_request(REQ_POP_LO, $urandom);
    end
    repeat (n_hi) begin
      if ($urandom_range(3) == 0) begin
        send_request(REQ_PEEK_HI, $urandom);
        sent++;
      end
      send_request(REQ_POP_HI, $urandom);
    end
    send_request(REQ_POP_LO, $urandom);
    send_request(REQ_PEEK_HI, $urandom);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_kind(input int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
    if (roll < 3 + push_pct) return $urandom_range(1) ? REQ_PUSH_LO : REQ_PUSH_HI;
    case ($urandom_range(9))
      0, 1, 2, 3: return REQ_POP_LO;
      4, 5, 6: return REQ_POP_HI;
      7, 8: return REQ_PEEK_LO;
      default: return REQ_PEEK_HI;
    endcase
  endfunction

  // Every kind on both stacks at reset capacity, word extremes and spare codes
  task automatic test_basic_ops();
    send_request(REQ_POP_LO, 32'h1234_5678);
    send_request(REQ_PEEK_HI, 32'h0);
    send_request(REQ_PUSH_LO, 32'h8000_0000);
    send_request(REQ_PUSH_HI, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_LO, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_HI, 32'h0000_0000);
    send_request(REQ_PEEK_LO, 32'h0);
    send_request(REQ_PEEK_HI, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_6, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_7, 32'h5A5A_A5A5);
    send_request(REQ_POP_LO, 32'h0);
    send_request(REQ_POP_LO, 32'h0);
    send_request(REQ_POP_LO, 32'h0);
    send_request(REQ_POP_HI, 32'h0);
    send_request(REQ_POP_HI, 32'h0);
  endtask

  // Zero capacity, a single entry, and a value above the store size
  task automatic test_capacity_extremes();
    write_capacity(7'd0);
    send_request(REQ_PUSH_LO, 32'hDEAD_BEEF);
    send_request(REQ_PUSH_HI, 32'hCAFE_F00D);
    send_request(REQ_POP_LO, 32'h0);
    send_request(REQ_PEEK_HI, 32'h0);
    write_capacity(7'd1);
    send_request(REQ_PUSH_HI, 32'h8000_0001);
    send_request(REQ_PUSH_LO, 32'h7FFF_FFFE);
    send_request(REQ_PEEK_HI, 32'h0);
    send_request(REQ_POP_HI, 32'h0);
    write_capacity(7'd127);
    send_request(REQ_PUSH_HI, 32'h0F0F_F0F0);
    send_request(REQ_PEEK_HI, 32'h0);
    send_request(REQ_POP_HI, 32'h0);
  endtask

  // A capacity write while a stack holds data must be dropped
  task automatic test_locked_capacity();
    int sent;
    write_capacity(7'd3);
    send_request(REQ_PUSH_LO, 32'h1111_1111);
    write_capacity(7'd1);
    send_request(REQ_PUSH_HI, 32'h2222_2222);
    send_request(REQ_PUSH_HI, 32'h3333_3333);
    send_request(REQ_PUSH_LO, 32'h4444_4444);
    send_request(REQ_PEEK_HI, 32'h0);
    empty_stacks(sent);
  endtask

  // Random fill-then-drain runs over a spread of capacities
  task automatic test_random_traffic(input int n_items, input int in_pct, input int out_pct);
    int sent;
    int len;
    int drained;
    logic [CAP_W-1:0] cap;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(7))
        0: cap = 7'd1;
        1: cap = 7'd2;
        2: cap = $urandom_range(3, 8);
        3: cap = 7'd64;
        4: cap = 7'd127;
        5: cap = $urandom_range(65, 127);
        6: cap = $urandom_range(0, 127);
        default: cap = $urandom_range(9, 20);
      endcase
      write_capacity(cap);
      len = (cap <= 8) ? $urandom_range(8, 24) : $urandom_range(30, 90);
      for (int i = 0; i < len; i++) begin
        send_request(pick_kind((i < (2 * len) / 3) ? 90 : 30), pick_word());
      end
      empty_stacks(drained);
      sent += len + drained;
    end
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_pct = 24;
    out_idle_pct = 87;
    test_basic_ops();
    test_capacity_extremes();
    test_locked_capacity();
    test_random_traffic(500, 24, 87);
    test_random_traffic(500, 87, 24);
    test_random_traffic(500, 0, 0);
    finish_batch();
    $display("Run covered %0d requests, %0d results, %0d capacity writes",
             req_count, result_count, cap_write_count);
    $display("Overflow results: %0d, underflow results: %0d, mismatches: %0d",
             overflow_count, underflow_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
